/* rtl/core/lcda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcda_pkg
// Shared types and constants of the least-cost device assigner.
// ----------------------------------------------------------------------------
package lcda_pkg;

    localparam int MAX_DEVICES  = 8;
    localparam int DEV_W        = $clog2(MAX_DEVICES);
    localparam int CNT_W        = 4;
    localparam int WARP_THREADS = 32;
    localparam int WARP_SHIFT   = $clog2(WARP_THREADS);
    localparam int THREADS_W    = 11;
    localparam int WPB_W        = THREADS_W - WARP_SHIFT + 1;  // warps per block
    localparam int WARPS_W      = WPB_W + 32;
    localparam int LOAD_W       = 64;
    localparam int WGT_W        = 32;
    localparam int COST_W       = LOAD_W + WGT_W + 2;
    localparam int PADDR_W      = 1;

    typedef enum logic [1:0] {
        CMD_ASSIGN  = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_WEIGHTS = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEMAND,
        ST_READ,
        ST_SUM,
        ST_MUL,
        ST_CMP,
        ST_WRITE,
        ST_OUT
    } t_state;

    localparam logic [PADDR_W-1:0] REG_DEVICE_COUNT = '0;

endpackage

/* rtl/core/lcda_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcda_task_if / lcda_result_if
// Valid/ready channels for task items and result items.
// ----------------------------------------------------------------------------
interface lcda_task_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  device_index;
    logic [10:0] block_threads;
    logic [31:0] grid_blocks;
    logic [31:0] copy_bytes;
    logic [23:0] warp_insts;
    logic [15:0] trans_per_warp;
    logic [7:0]  bytes_per_trans;
    logic [31:0] copy_weight;
    logic [31:0] inst_weight;
    logic [31:0] mem_weight;

    modport source (output valid, command, device_index, block_threads, grid_blocks,
                    copy_bytes, warp_insts, trans_per_warp, bytes_per_trans,
                    copy_weight, inst_weight, mem_weight, input ready);
    modport sink   (input valid, command, device_index, block_threads, grid_blocks,
                    copy_bytes, warp_insts, trans_per_warp, bytes_per_trans,
                    copy_weight, inst_weight, mem_weight, output ready);
endinterface

interface lcda_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] chosen_device;
    logic       saturated;

    modport source (output valid, chosen_device, saturated, input ready);
    modport sink   (input valid, chosen_device, saturated, output ready);
endinterface

/* rtl/core/lcda_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcda_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/least_cost_device_assigner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_cost_device_assigner
// Load-balancing dispatcher: picks the device with the lowest weighted cost.
// ----------------------------------------------------------------------------
// Usage:
//   i_task carries one command per transaction (assign, release, load weights);
//   o_result returns exactly one transaction per task: the chosen device for
//   assign, otherwise the echoed device index, plus a saturation flag.
//   device_count is written over the APB port at address 0 while idle: a rule
//   for the user, which the block itself does not enforce.
// Sequencing: one task at a time. Load weights: one weight RAM write.
//   Release: six steps of demand on the shared 32x32 multiplier, one load
//   RAM read, write back. Assign: the same six demand steps, then per device
//   one RAM read, one saturating add, six multiply-accumulate steps and one
//   compare, then write back. The shared multiplier sets these steps.
// Reset:
//   Synchronous, active low. Load totals and weights read as zero until
//   written (per-entry valid bits); device_count returns to 1.
// Stall:
//   A result waits in the output register while o_result.ready is low; the
//   next task is still taken, and its result waits for the register to free.
// ----------------------------------------------------------------------------
module least_cost_device_assigner (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lcda_task_if.sink                    i_task,
    lcda_result_if.source                o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lcda_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lcda_pkg::*;

    localparam int LRAM_W = 3 * LOAD_W;
    localparam int WRAM_W = 3 * WGT_W;

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_dev_count;
    logic [CNT_W-1:0]   w_eff_count;
    t_cmd               r_cmd;
    logic [DEV_W-1:0]   r_index;
    logic [WARPS_W-1:0] r_warps;
    logic [31:0]        r_copy;
    logic [23:0]        r_ipw;
    logic [15:0]        r_tpw;
    logic [7:0]         r_bpt;
    logic [WRAM_W-1:0]  r_new_wgt;
    logic [2:0]         r_step;
    logic [COST_W-1:0]  r_acc, n_acc;
    logic [LOAD_W-1:0]  r_insts;
    logic [LOAD_W-1:0]  r_mem_dem;
    logic [LOAD_W-1:0]  r_wt;
    logic [DEV_W-1:0]   r_dev;
    logic [LOAD_W-1:0]  r_x [3];
    logic [LOAD_W-1:0]  n_x [3];
    logic               r_x_clip, n_x_clip;
    logic [WRAM_W-1:0]  r_wgt;
    logic [COST_W-1:0]  r_best;
    logic [DEV_W-1:0]   r_chosen;
    logic [LOAD_W-1:0]  r_best_x [3];
    logic               r_best_clip;
    logic               r_ovalid;
    logic [DEV_W-1:0]   r_ochosen;
    logic               r_osat;
    logic [MAX_DEVICES-1:0] r_lvld, r_wvld;
    logic               r_rvld_l, r_rvld_w;

    logic               w_accept, w_last_dev, w_better;
    logic               w_lram_we, w_wram_we;
    logic [DEV_W-1:0]   w_lram_waddr;
    logic [LRAM_W-1:0]  w_lram_wdata, w_lram_rdata, w_lram_rd;
    logic [WRAM_W-1:0]  w_wram_rdata, w_wram_rd;
    logic [31:0]        w_mul_a, w_mul_b;
    logic [63:0]        w_prod;
    logic               w_fresh, w_hi;
    logic [1:0]         w_op;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DEVICE_COUNT) ? {{(32-CNT_W){1'b0}}, r_dev_count} : '0;

    assign i_task.ready = (r_state == ST_IDLE);
    assign w_accept     = i_task.valid && i_task.ready;

    assign o_result.valid         = r_ovalid;
    assign o_result.chosen_device = r_ochosen;
    assign o_result.saturated     = r_osat;

    // Clamp the device count to 1..MAX_DEVICES.
    always_comb begin
        if (r_dev_count == '0) begin
            w_eff_count = CNT_W'(1);
        end else if (r_dev_count > CNT_W'(MAX_DEVICES)) begin
            w_eff_count = CNT_W'(MAX_DEVICES);
        end else begin
            w_eff_count = r_dev_count;
        end
    end
    assign w_last_dev = (CNT_W'(r_dev) + CNT_W'(1)) >= w_eff_count;
    assign w_better   = (r_dev == '0) || (r_acc < r_best);

    lcda_ram #(.WIDTH(LRAM_W), .DEPTH(MAX_DEVICES)) u_load_ram (
        .i_clk   (i_clk),
        .i_we    (w_lram_we),
        .i_waddr (w_lram_waddr),
        .i_wdata (w_lram_wdata),
        .i_raddr (r_dev),
        .o_rdata (w_lram_rdata)
    );

    lcda_ram #(.WIDTH(WRAM_W), .DEPTH(MAX_DEVICES)) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_wram_we),
        .i_waddr (r_index),
        .i_wdata (r_new_wgt),
        .i_raddr (r_dev),
        .o_rdata (w_wram_rdata)
    );

    // Entries never written read as zero.
    assign w_lram_rd = r_rvld_l ? w_lram_rdata : '0;
    assign w_wram_rd = r_rvld_w ? w_wram_rdata : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_task.command == CMD_ASSIGN || i_task.command == CMD_RELEASE) begin
                        n_state = ST_DEMAND;
                    end else if (i_task.command == CMD_WEIGHTS) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_DEMAND: if (r_step == 3'd5) n_state = ST_READ;
            ST_READ:   n_state = ST_SUM;
            ST_SUM:    n_state = (r_cmd == CMD_RELEASE) ? ST_WRITE : ST_MUL;
            ST_MUL:    if (r_step == 3'd5) n_state = ST_CMP;
            ST_CMP:    n_state = w_last_dev ? ST_WRITE : ST_READ;
            ST_WRITE:  n_state = ST_OUT;
            ST_OUT:    if (!r_ovalid || o_result.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Multiplier operands and RAM write controls.
    always_comb begin
        w_mul_a      = '0;
        w_mul_b      = '0;
        w_fresh      = 1'b0;
        w_hi         = r_step[0];
        w_op         = 2'(r_step >> 1);
        w_lram_we    = 1'b0;
        w_wram_we    = 1'b0;
        w_lram_waddr = r_chosen;
        w_lram_wdata = {r_best_x[2], r_best_x[1], r_best_x[0]};
        case (r_state)
            ST_DEMAND: begin
                w_fresh = !r_step[0];
                case (w_op)
                    2'd0: begin
                        w_mul_a = r_step[0] ? 32'(r_warps[WARPS_W-1:32]) : r_warps[31:0];
                        w_mul_b = 32'(r_ipw);
                    end
                    2'd1: begin
                        w_mul_a = r_step[0] ? 32'(r_warps[WARPS_W-1:32]) : r_warps[31:0];
                        w_mul_b = 32'(r_tpw);
                    end
                    default: begin
                        w_mul_a = r_step[0] ? r_wt[63:32] : r_wt[31:0];
                        w_mul_b = 32'(r_bpt);
                    end
                endcase
            end
            ST_MUL: begin
                w_fresh = (r_step == '0);
                w_mul_a = r_step[0] ? r_x[w_op][63:32] : r_x[w_op][31:0];
                case (w_op)
                    2'd0:    w_mul_b = r_wgt[WGT_W-1:0];
                    2'd1:    w_mul_b = r_wgt[2*WGT_W-1:WGT_W];
                    default: w_mul_b = r_wgt[3*WGT_W-1:2*WGT_W];
                endcase
            end
            ST_WRITE: begin
                w_lram_we = (r_cmd == CMD_ASSIGN || r_cmd == CMD_RELEASE);
                w_wram_we = (r_cmd == CMD_WEIGHTS);
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign n_acc  = (w_fresh ? '0 : r_acc)
                  + (w_hi ? COST_W'({w_prod, 32'b0}) : COST_W'(w_prod));

    // Saturating add for assign, clipping subtract for release.
    always_comb begin
        logic [LOAD_W-1:0] v_load, v_dem;
        logic [LOAD_W:0]   v_sum;
        n_x_clip = 1'b0;
        for (int j = 0; j < 3; j++) begin
            v_load = w_lram_rd[j*LOAD_W +: LOAD_W];
            v_dem  = (j == 0) ? LOAD_W'(r_copy) : ((j == 1) ? r_insts : r_mem_dem);
            if (r_cmd == CMD_RELEASE) begin
                v_sum = {1'b0, v_load} - {1'b0, v_dem};
                if (v_dem > v_load) begin
                    n_x[j]   = '0;
                    n_x_clip = 1'b1;
                end else begin
                    n_x[j] = v_sum[LOAD_W-1:0];
                end
            end else begin
                v_sum = {1'b0, v_load} + {1'b0, v_dem};
                if (v_sum[LOAD_W]) begin
                    n_x[j]   = '1;
                    n_x_clip = 1'b1;
                end else begin
                    n_x[j] = v_sum[LOAD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dev_count <= CNT_W'(1);
            r_ovalid    <= 1'b0;
            r_lvld      <= '0;
            r_wvld      <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr == REG_DEVICE_COUNT) begin
                r_dev_count <= pwdata[CNT_W-1:0];
            end
            if (w_lram_we) r_lvld[w_lram_waddr] <= 1'b1;
            if (w_wram_we) r_wvld[r_index] <= 1'b1;
            if (r_state == ST_OUT && (!r_ovalid || o_result.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvld_l <= r_lvld[r_dev];
        r_rvld_w <= r_wvld[r_dev];
        if (w_accept) begin
            r_cmd     <= t_cmd'(i_task.command);
            r_index   <= i_task.device_index;
            r_warps   <= WARPS_W'(WPB_W'((12'(i_task.block_threads) + 12'(WARP_THREADS - 1))
                                  >> WARP_SHIFT)) * WARPS_W'(i_task.grid_blocks);
            r_copy    <= i_task.copy_bytes;
            r_ipw     <= i_task.warp_insts;
            r_tpw     <= i_task.trans_per_warp;
            r_bpt     <= i_task.bytes_per_trans;
            r_new_wgt <= {i_task.mem_weight, i_task.inst_weight, i_task.copy_weight};
            r_step    <= '0;
            r_dev     <= (i_task.command == CMD_RELEASE) ? i_task.device_index : '0;
            r_chosen  <= i_task.device_index;
            r_best_clip <= 1'b0;
        end
        case (r_state)
            ST_DEMAND: begin
                r_acc  <= n_acc;
                r_step <= (r_step == 3'd5) ? '0 : r_step + 3'd1;
                if (r_step == 3'd2) r_insts <= r_acc[LOAD_W-1:0];
                if (r_step == 3'd3) r_wt <= n_acc[LOAD_W-1:0];
                if (r_step == 3'd5) r_mem_dem <= n_acc[LOAD_W-1:0];
            end
            ST_SUM: begin
                r_x      <= n_x;
                r_x_clip <= n_x_clip;
                r_wgt    <= w_wram_rd;
                if (r_cmd == CMD_RELEASE) begin
                    r_best_x    <= n_x;
                    r_best_clip <= n_x_clip;
                end
            end
            ST_MUL: begin
                r_acc  <= n_acc;
                r_step <= (r_step == 3'd5) ? '0 : r_step + 3'd1;
            end
            ST_CMP: begin
                if (w_better) begin
                    r_best      <= r_acc;
                    r_chosen    <= r_dev;
                    r_best_x    <= r_x;
                    r_best_clip <= r_x_clip;
                end
                if (!w_last_dev) r_dev <= r_dev + DEV_W'(1);
            end
            ST_OUT: begin
                if (!r_ovalid || o_result.ready) begin
                    r_ochosen <= r_chosen;
                    r_osat    <= (r_cmd == CMD_ASSIGN || r_cmd == CMD_RELEASE) && r_best_clip;
                end
            end
            default: begin
            end
        endcase
    end
endmodule

/* rtl/core/lcda_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcda_checker
// Port-level checks of the least-cost device assigner, bound to the top level.
// ----------------------------------------------------------------------------
module lcda_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_chosen,
    input logic       i_pready
);
    // One task in flight: the sink closes right after a transaction.
    a_one_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("task accepted while another is in flight");

    // Nothing comes out the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its device.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_chosen)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready dropped");
endmodule

bind least_cost_device_assigner lcda_checker u_lcda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_task.valid),
    .i_in_ready   (i_task.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_chosen (o_result.chosen_device),
    .i_pready     (pready)
);

/* test/least_cost_device_assigner_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_cost_device_assigner_test
// Drives assign, release and weight tasks through the dispatcher under random
// idling on both channels, predicts each result from a local copy of the load
// totals and weights, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module least_cost_device_assigner_test;
    import lcda_pkg::*;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  device_index;
        logic [10:0] block_threads;
        logic [31:0] grid_blocks;
        logic [31:0] copy_bytes;
        logic [23:0] warp_insts;
        logic [15:0] trans_per_warp;
        logic [7:0]  bytes_per_trans;
        logic [31:0] copy_weight;
        logic [31:0] inst_weight;
        logic [31:0] mem_weight;
    } t_task;

    typedef struct packed {
        logic [2:0] chosen_device;
        logic       saturated;
    } t_pick;

    typedef struct {
        t_task task_item;
        bit    known;
        t_pick pick;
    } t_row;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam int          CYCLE_LIMIT = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcda_task_if   task_ch ();
    lcda_result_if result_ch ();

    least_cost_device_assigner dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_task   (task_ch.sink),
        .o_result (result_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic [63:0] copy_total [MAX_DEVICES];
    logic [63:0] inst_total [MAX_DEVICES];
    logic [63:0] mem_total  [MAX_DEVICES];
    logic [31:0] weights    [MAX_DEVICES][3];
    logic [3:0]  active_devices;

    t_pick  pending_picks [$];
    int     mismatches;
    int     cycles;
    int     send_idle_pct;
    int     recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [63:0] clip_mul(logic [63:0] a, logic [63:0] b, ref bit clip);
        logic [127:0] p;
        p = a * b;
        if (p[127:64] != 0) begin
            clip = 1;
            return ALL_ONES;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b, ref bit clip);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            clip = 1;
            return ALL_ONES;
        end
        return s[63:0];
    endfunction

    function automatic t_pick dispatch(t_task t);
        bit           clip;
        bit           scratch;
        logic [63:0]  warps, insts, mem;
        logic [127:0] cost, best;
        int           count;
        int           pick;
        t_pick        r;
        clip = 0;
        pick = t.device_index;
        warps = clip_mul((64'(t.block_threads) + WARP_THREADS - 1) / WARP_THREADS,
                         64'(t.grid_blocks), clip);
        insts = clip_mul(warps, 64'(t.warp_insts), clip);
        mem   = clip_mul(clip_mul(warps, 64'(t.trans_per_warp), clip),
                         64'(t.bytes_per_trans), clip);
        case (t.command)
            CMD_ASSIGN: begin
                count = active_devices;
                if (count == 0) count = 1;
                if (count > MAX_DEVICES) count = MAX_DEVICES;
                pick = 0;
                best = 0;
                for (int d = 0; d < count; d++) begin
                    scratch = 0;
                    cost = clip_add(copy_total[d], 64'(t.copy_bytes), scratch)
                           * 128'(weights[d][0])
                         + clip_add(inst_total[d], insts, scratch) * 128'(weights[d][1])
                         + clip_add(mem_total[d], mem, scratch) * 128'(weights[d][2]);
                    if (d == 0 || cost < best) begin
                        best = cost;
                        pick = d;
                    end
                end
                copy_total[pick] = clip_add(copy_total[pick], 64'(t.copy_bytes), clip);
                inst_total[pick] = clip_add(inst_total[pick], insts, clip);
                mem_total[pick]  = clip_add(mem_total[pick], mem, clip);
            end
            CMD_RELEASE: begin
                // drain toward zero, clipping where the demand exceeds the total
                if (64'(t.copy_bytes) > copy_total[pick]) begin
                    clip = 1; copy_total[pick] = 0;
                end else copy_total[pick] -= 64'(t.copy_bytes);
                if (insts > inst_total[pick]) begin
                    clip = 1; inst_total[pick] = 0;
                end else inst_total[pick] -= insts;
                if (mem > mem_total[pick]) begin
                    clip = 1; mem_total[pick] = 0;
                end else mem_total[pick] -= mem;
            end
            CMD_WEIGHTS: begin
                weights[pick][0] = t.copy_weight;
                weights[pick][1] = t.inst_weight;
                weights[pick][2] = t.mem_weight;
                clip = 0;
            end
            default: clip = 0;
        endcase
        r.chosen_device = 3'(pick);
        r.saturated = clip;
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // result monitor and random backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (pending_picks.size() == 0) begin
                    report("unexpected result", result_ch.chosen_device, -1);
                end else begin
                    if (result_ch.chosen_device != pending_picks[0].chosen_device)
                        report("chosen_device", result_ch.chosen_device,
                               pending_picks[0].chosen_device);
                    if (result_ch.saturated != pending_picks[0].saturated)
                        report("saturated", result_ch.saturated,
                               pending_picks[0].saturated);
                    void'(pending_picks.pop_front());
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_count(logic [3:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_DEVICE_COUNT; pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        active_devices = value;
    endtask

    task automatic wait_drained();
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // present one task; the prediction is queued at the accepting edge
    task automatic send(t_task t, bit known, t_pick want);
        t_pick p;
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        task_ch.valid <= 1'b1;
        task_ch.command <= t.command; task_ch.device_index <= t.device_index;
        task_ch.block_threads <= t.block_threads; task_ch.grid_blocks <= t.grid_blocks;
        task_ch.copy_bytes <= t.copy_bytes; task_ch.warp_insts <= t.warp_insts;
        task_ch.trans_per_warp <= t.trans_per_warp;
        task_ch.bytes_per_trans <= t.bytes_per_trans;
        task_ch.copy_weight <= t.copy_weight; task_ch.inst_weight <= t.inst_weight;
        task_ch.mem_weight <= t.mem_weight;
        do @(posedge i_clk); while (!task_ch.ready);
        task_ch.valid <= 1'b0;
        p = dispatch(t);
        if (known && p != want) report("table row", p, want);
        pending_picks.push_back(p);
        // the sink is closed for the next cycle anyway
        @(posedge i_clk);
    endtask

    function automatic t_task mk(logic [1:0] c, logic [2:0] d, logic [10:0] th,
                                 logic [31:0] gb, logic [31:0] cb, logic [23:0] ipw,
                                 logic [15:0] tpw, logic [7:0] bpt, logic [31:0] w0,
                                 logic [31:0] w1, logic [31:0] w2);
        t_task t;
        t = '{c, d, th, gb, cb, ipw, tpw, bpt, w0, w1, w2};
        return t;
    endfunction

    function automatic t_task random_task(int devs);
        t_task t;
        int    k;
        t = '{default: '0};
        k = $urandom_range(99);
        t.command = k < 50 ? CMD_ASSIGN : k < 75 ? CMD_RELEASE : k < 95 ? CMD_WEIGHTS : CMD_NONE;
        t.device_index = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(devs - 1));
        t.block_threads = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
        t.grid_blocks = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 4096);
        t.copy_bytes = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 1 << 20);
        t.warp_insts = 24'($urandom);
        t.trans_per_warp = 16'($urandom);
        t.bytes_per_trans = 8'($urandom);
        t.copy_weight = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 18);
        t.inst_weight = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 18);
        t.mem_weight = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 18);
        return t;
    endfunction

    t_row        plan [$];
    t_pick       none;
    logic [3:0]  counts [5] = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd1};

    initial begin
        cycles = 0; mismatches = 0;
        send_idle_pct = 20; recv_idle_pct = 72;
        none = '0;
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        task_ch.valid = 0;
        {task_ch.command, task_ch.device_index, task_ch.block_threads,
         task_ch.grid_blocks, task_ch.copy_bytes, task_ch.warp_insts,
         task_ch.trans_per_warp, task_ch.bytes_per_trans, task_ch.copy_weight,
         task_ch.inst_weight, task_ch.mem_weight} = '0;
        for (int d = 0; d < MAX_DEVICES; d++) begin
            copy_total[d] = 0; inst_total[d] = 0; mem_total[d] = 0;
            weights[d] = '{0, 0, 0};
        end
        active_devices = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed rows: single device after reset, extremes, clipping, unused command
        plan.push_back('{mk(CMD_ASSIGN, 5, 1, 1, 0, 0, 0, 0, 0, 0, 0), 1, '{3'd0, 1'b0}});
        plan.push_back('{mk(CMD_ASSIGN, 0, 1024, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF,
                         16'hFFFF, 8'hFF, 0, 0, 0), 1, '{3'd0, 1'b0}});
        plan.push_back('{mk(CMD_RELEASE, 0, 1, 1, 1, 1, 1, 1, 0, 0, 0), 0, none});
        plan.push_back('{mk(CMD_RELEASE, 3, 1, 1, 1, 0, 0, 0, 0, 0, 0), 1, '{3'd3, 1'b1}});
        plan.push_back('{mk(CMD_WEIGHTS, 7, 1, 1, 1, 1, 1, 1, 32'hFFFFFFFF, 32'hFFFFFFFF,
                         32'hFFFFFFFF), 1, '{3'd7, 1'b0}});
        plan.push_back('{mk(CMD_NONE, 6, 1024, 32'hFFFFFFFF, 5, 5, 5, 5, 0, 0, 0), 1,
                         '{3'd6, 1'b0}});
        plan.push_back('{mk(CMD_ASSIGN, 0, 0, 0, 7, 9, 9, 9, 0, 0, 0), 1, '{3'd0, 1'b0}});
        for (int i = 0; i < plan.size(); i++)
            send(plan[i].task_item, plan[i].known, plan[i].pick);
        wait_drained();

        write_count(4'd8);
        plan.delete();
        for (int d = 0; d < MAX_DEVICES; d++)
            plan.push_back('{mk(CMD_WEIGHTS, 3'(d), 1, 1, 0, 0, 0, 0, 32'(1 << 16) + d,
                             32'(d * 3), 32'(1 << (d + 8))), 1, '{3'(d), 1'b0}});
        plan.push_back('{mk(CMD_ASSIGN, 0, 33, 7, 1000, 50, 4, 32, 0, 0, 0), 0, none});
        plan.push_back('{mk(CMD_ASSIGN, 0, 1024, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF,
                         16'hFFFF, 8'hFF, 0, 0, 0), 0, none});
        plan.push_back('{mk(CMD_RELEASE, 2, 1024, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF,
                         16'hFFFF, 8'hFF, 0, 0, 0), 0, none});
        for (int i = 0; i < plan.size(); i++)
            send(plan[i].task_item, plan[i].known, plan[i].pick);
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            int devs;
            if (phase == 2) begin send_idle_pct = 72; recv_idle_pct = 20; end
            if (phase == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_count(counts[phase]);
            devs = counts[phase] == 0 ? 1 : counts[phase] > 8 ? 8 : counts[phase];
            for (int n = 0; n < 270; n++) begin
                if (n == 135) wait_drained();
                send(random_task(devs), 0, none);
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
